/* src/sliding_window_median_top_defines.svh */
// ----------------------------------------------------------------------------
// sliding window median: assertion macros
// shared assertion helpers for the rtl files of the median filter
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked at every edge outside reset
`define SWM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define SWM_ASSERT(lbl, clk, rst_n, prop)
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// shared types and constants of the sliding window median filter
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

	// window length register
	localparam int WL_BITS = 7;
	localparam logic [WL_BITS-1:0] WL_RESET = 7'd64;

	// broadcast to every cell of the sorted chain
	typedef struct packed {
		logic load;   // a request is taken this cycle
		logic evict;  // window is full, oldest sample leaves
	} swm_ctrl_t;

	// status of the output queue
	typedef struct packed {
		logic [1:0] occ;  // entries held
		logic       pop;  // head taken this cycle
	} swm_q_stat_t;

endpackage

`default_nettype wire

/* src/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell
// one position of the sorted chain: delete and insert from neighbor values
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell
	import swm_pkg::*;
#(
	parameter int W = 32
) (
	input  wire logic                clk,
	input  wire swm_ctrl_t           ctrl,
	input  wire logic signed [W-1:0] in_val,   // incoming sample
	input  wire logic signed [W-1:0] old_val,  // sample being evicted
	input  wire logic signed [W-1:0] up_val,   // stored value of upper neighbor
	input  wire logic                up_le,    // upper neighbor <= incoming
	input  wire logic signed [W-1:0] dn_r,     // lower neighbor after removal
	input  wire logic                dn_rle,   // lower neighbor after removal <= incoming
	input  wire logic                rvalid,   // position still occupied after removal
	output logic signed [W-1:0]      val,
	output logic                     le,
	output logic signed [W-1:0]      r_val,
	output logic                     r_le
);

	logic signed [W-1:0] val_q;
	logic                ge_old;

	// first cell at or above the evicted value holds it: everything from there shifts down
	assign ge_old = ctrl.evict && (val_q >= old_val);
	assign le     = (val_q <= in_val);
	assign r_val  = ge_old ? up_val : val_q;
	assign r_le   = rvalid && (ge_old ? up_le : le);
	assign val    = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			if (r_le) begin
				val_q <= r_val;
			end else if (dn_rle) begin
				val_q <= in_val;
			end else begin
				val_q <= dn_r;
			end
		end
	end

endmodule

`default_nettype wire

/* src/swm_outq.sv */
// ----------------------------------------------------------------------------
// swm_outq
// two-entry result queue between the filter and the receiver
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_median_top_defines.svh"

module swm_outq
	import swm_pkg::*;
#(
	parameter int DW = 34
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] push_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [DW-1:0]      out_data,
	output swm_q_stat_t        stat
);

	logic [1:0]    occ_q;
	logic [1:0]    occ_d;
	logic [DW-1:0] ent_q [2];
	logic          pop;

	assign out_valid = (occ_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = ent_q[0];
	assign stat.occ  = occ_q;
	assign stat.pop  = pop;

	always_comb begin
		unique case ({push, pop})
			2'b10:   occ_d = occ_q + 2'd1;
			2'b01:   occ_d = occ_q - 2'd1;
			default: occ_d = occ_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q[0] <= (occ_q == 2'd2) ? ent_q[1] : push_data;
			if (push && (occ_q == 2'd2)) begin
				ent_q[1] <= push_data;
			end
		end else if (push) begin
			if (occ_q == 2'd0) begin
				ent_q[0] <= push_data;
			end else begin
				ent_q[1] <= push_data;
			end
		end
	end

	`SWM_ASSERT(a_no_overflow, clk, arst_n, !(push && (occ_q == 2'd2) && !pop))

endmodule

`default_nettype wire

/* src/sliding_window_median_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_median_top
// running median over the most recent window_length signed samples
//
// one sample per request on the input channel (in_valid / in_stall), one
// result per sample on the output channel (out_valid / out_stall): twice the
// median of the samples held, and window_full once window_length samples are in.
// until the window fills, the median covers every sample seen so far.
// throughput: one sample per cycle while in_stall is low; the sorted chain
// updates every cell in the cycle a sample is taken, and the arrival ring
// gives the evicted value from a prefetched read of its single read port.
// the result is picked from the chain the cycle after the update and lands in
// a two-entry output queue; in_stall rises only when that queue cannot take
// another result, so a stalled receiver holds the input back after two results.
// writing window_length (cfg_wr_en / cfg_wr_data) empties the window; do it
// only while no sample is in flight. 0 acts as 1, values above MAX_WINDOW act
// as MAX_WINDOW.
// reset: window empty, window_length 64, output queue empty; sample storage
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_median_top_defines.svh"

module sliding_window_median_top
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_wr_en,
	input  wire logic [WL_BITS-1:0]          cfg_wr_data,
	// sample requests
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	// result requests
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [SAMPLE_BITS:0]      median_doubled,
	output logic                             window_full
);

	localparam int W  = SAMPLE_BITS;
	localparam int CW = $clog2(MAX_WINDOW + 1);              // holds 0..MAX_WINDOW
	localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LW = (CW > WL_BITS) ? CW : WL_BITS;
	localparam int DW = W + 2;                               // median plus full flag

	// window length and occupancy
	logic [WL_BITS-1:0] wl_q;
	logic [CW-1:0]      len_eff;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_n;
	logic [CW-1:0]      rcount;
	logic               full_now;
	logic               in_accept;

	// arrival ring
	logic signed [W-1:0] ring_mem [MAX_WINDOW];
	logic [PW-1:0]       wp_q;
	logic [PW-1:0]       rp_q;
	logic [PW-1:0]       wp_inc;
	logic [PW-1:0]       rp_inc;
	logic [PW-1:0]       rp_n;
	logic signed [W-1:0] old_q;                              // value at rp_q

	// sorted chain
	swm_ctrl_t           ctrl;
	logic signed [W-1:0] cell_val [MAX_WINDOW];
	logic                cell_le  [MAX_WINDOW];
	logic signed [W-1:0] cell_r   [MAX_WINDOW];
	logic                cell_rle [MAX_WINDOW];

	// median pick stage
	logic                s1_q;
	logic [CW-1:0]       idx_lo_s1;
	logic [CW-1:0]       idx_hi_s1;
	logic                full_s1;
	logic signed [W-1:0] mid_lo;
	logic signed [W-1:0] mid_hi;
	logic signed [W:0]   median_sum;

	// output queue
	swm_q_stat_t         q_stat;
	logic [DW-1:0]       q_data;
	logic [2:0]          q_lvl;

	// zero acts as one, anything past the storage acts as its size
	always_comb begin
		if (wl_q == '0) begin
			len_eff = CW'(1);
		end else if (LW'(wl_q) > LW'(MAX_WINDOW)) begin
			len_eff = CW'(MAX_WINDOW);
		end else begin
			len_eff = CW'(LW'(wl_q));
		end
	end

	assign full_now = (count_q >= len_eff);
	assign count_n  = full_now ? count_q : count_q + CW'(1);
	assign rcount   = full_now ? count_q - CW'(1) : count_q;

	// hold input back unless the queue has room for this result when it is pushed
	assign q_lvl     = {1'b0, q_stat.occ} + {2'b00, s1_q};
	assign in_stall  = q_stat.pop ? (q_lvl >= 3'd3) : (q_lvl >= 3'd2);
	assign in_accept = in_valid && !in_stall;

	assign ctrl.load  = in_accept;
	assign ctrl.evict = full_now;

	// ring pointers
	assign wp_inc = (wp_q == PW'(MAX_WINDOW - 1)) ? '0 : wp_q + PW'(1);
	assign rp_inc = (rp_q == PW'(MAX_WINDOW - 1)) ? '0 : rp_q + PW'(1);
	assign rp_n   = (in_accept && full_now) ? rp_inc : rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= WL_RESET;
			count_q <= '0;
			wp_q    <= '0;
			rp_q    <= '0;
			s1_q    <= 1'b0;
		end else begin
			s1_q <= in_accept;
			if (cfg_wr_en) begin
				wl_q    <= cfg_wr_data;
				count_q <= '0;
				wp_q    <= '0;
				rp_q    <= '0;
			end else if (in_accept) begin
				count_q <= count_n;
				wp_q    <= wp_inc;
				rp_q    <= rp_n;
			end
		end
	end

	// ring write plus prefetch of the next value to evict, bypassing a same-slot write
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ring_mem[wp_q] <= sample;
		end
		if (in_accept && (rp_n == wp_q)) begin
			old_q <= sample;
		end else begin
			old_q <= ring_mem[rp_n];
		end
	end

	// sorted chain, ascending from cell 0
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic signed [W-1:0] up_v;
		logic                up_l;
		logic signed [W-1:0] dn_v;
		logic                dn_l;
		logic                rvalid;

		if (i == MAX_WINDOW - 1) begin : g_top_end
			// never read: the top cell is never kept once a sample leaves
			assign up_v = sample;
			assign up_l = 1'b0;
		end else begin : g_top_link
			assign up_v = cell_val[i+1];
			assign up_l = cell_le[i+1];
		end

		if (i == 0) begin : g_bot_end
			assign dn_v = sample;
			assign dn_l = 1'b1;
		end else begin : g_bot_link
			assign dn_v = cell_r[i-1];
			assign dn_l = cell_rle[i-1];
		end

		assign rvalid = (rcount > CW'(i));

		swm_cell #(
			.W(W)
		) u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.in_val (sample),
			.old_val(old_q),
			.up_val (up_v),
			.up_le  (up_l),
			.dn_r   (dn_v),
			.dn_rle (dn_l),
			.rvalid (rvalid),
			.val    (cell_val[i]),
			.le     (cell_le[i]),
			.r_val  (cell_r[i]),
			.r_le   (cell_rle[i])
		);
	end

	// middle positions for the count after this sample
	always_ff @(posedge clk) begin
		if (in_accept) begin
			idx_lo_s1 <= (count_n - CW'(1)) >> 1;
			idx_hi_s1 <= count_n >> 1;
			full_s1   <= (count_n >= len_eff);
		end
	end

	// pick the two middle cells; equal for an odd count
	always_comb begin
		mid_lo = '0;
		mid_hi = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (idx_lo_s1 == CW'(i)) begin
				mid_lo = mid_lo | cell_val[i];
			end
			if (idx_hi_s1 == CW'(i)) begin
				mid_hi = mid_hi | cell_val[i];
			end
		end
	end

	assign median_sum = {mid_lo[W-1], mid_lo} + {mid_hi[W-1], mid_hi};

	swm_outq #(
		.DW(DW)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s1_q),
		.push_data({median_sum, full_s1}),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (q_data),
		.stat     (q_stat)
	);

	assign median_doubled = q_data[DW-1:1];
	assign window_full    = q_data[0];

	`SWM_ASSERT(a_count_bound, clk, arst_n, count_q <= len_eff)
	`SWM_ASSERT_NEXT(a_full_holds_count, clk, arst_n, in_accept && full_now && !cfg_wr_en, count_q == $past(count_q))
	`SWM_ASSERT(a_no_stall_when_empty, clk, arst_n, !((q_stat.occ == 2'd0) && !s1_q && in_stall))

endmodule

`default_nettype wire
